FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CPSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cpsp: implication check failed");

// Next-cycle implication, disabled during reset.
`define CPSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cpsp: next-cycle check failed");

`endif

FILE: rtl/cpsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsp_pkg
// Shared types and constants of the cascaded position/speed PI controller.
// ----------------------------------------------------------------------------
package cpsp_pkg;

  localparam int GAIN_W   = 24;
  localparam int DATA_W   = 32;
  localparam int SPEED_W  = 16;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;
  localparam int FRAC_W   = 16;

  // register indexes
  localparam logic [1:0] REG_POS_KP = 2'd0;
  localparam logic [1:0] REG_POS_KI = 2'd1;
  localparam logic [1:0] REG_SPD_KP = 2'd2;
  localparam logic [1:0] REG_SPD_KI = 2'd3;

  // reset gains, Q8.16
  localparam logic [GAIN_W-1:0] POS_KP_RST = 24'd983040;
  localparam logic [GAIN_W-1:0] POS_KI_RST = 24'd655;
  localparam logic [GAIN_W-1:0] SPD_KP_RST = 24'd6553600;
  localparam logic [GAIN_W-1:0] SPD_KI_RST = 24'd6553600;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL
  } alu_op_t;

  typedef struct packed {
    logic [GAIN_W-1:0] pos_kp;
    logic [GAIN_W-1:0] pos_ki;
    logic [GAIN_W-1:0] spd_kp;
    logic [GAIN_W-1:0] spd_ki;
  } gains_t;

endpackage

FILE: rtl/cpsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsp_if
// Valid/ready channels for measurement transactions and drive results.
// ----------------------------------------------------------------------------
interface cpsp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position_measured;
  logic signed [31:0] position_target;
  logic signed [15:0] speed_measured;

  modport source (output valid, output position_measured, output position_target,
                  output speed_measured, input ready);
  modport sink   (input valid, input position_measured, input position_target,
                  input speed_measured, output ready);
endinterface

interface cpsp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive_value;

  modport source (output valid, output drive_value, input ready);
  modport sink   (input valid, input drive_value, output ready);
endinterface

FILE: rtl/cascaded_position_speed_pi.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_position_speed_pi
// Cascaded positional PI / incremental speed PI controller, one shared ALU.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake        | payload
//  in_ch    | in  | valid/ready      | position_measured, position_target,
//           |     |                  | speed_measured
//  out_ch   | out | valid/ready      | drive_value
//  cfg_*    | in  | APB, pready = 1  | gains pos_kp, pos_ki, spd_kp, spd_ki
//
// A transaction is accepted while the sequencer is idle, then the sequencer
// runs 12 ALU steps, one per cycle, through the single shared add/sub/multiply
// unit; the last step loads the drive value into the output register.
// The last step waits while the output register still holds an untaken result.
// in_ch.ready is high only while the sequencer is idle.
// Synchronous active-low reset clears the loop state and restores reset gains.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cascaded_position_speed_pi
  import cpsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  cpsp_in_if.sink           in_ch,
  cpsp_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef enum logic [3:0] {
    SQ_PERR,
    SQ_PSUM,
    SQ_PKP,
    SQ_PKI,
    SQ_OUTER,
    SQ_NEG,
    SQ_SERR,
    SQ_DLT,
    SQ_SKP,
    SQ_SKI,
    SQ_INC,
    SQ_DRV
  } step_t;

  gains_t gains;

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_drive_r, out_drive_nxt;
  logic signed [DATA_W-1:0] pes_r, pes_nxt;
  logic signed [DATA_W-1:0] prev_r, prev_nxt;
  logic signed [DATA_W-1:0] drv_r, drv_nxt;

  // working registers
  logic signed [DATA_W-1:0]  pm_r, pt_r;
  logic signed [SPEED_W-1:0] sp_r;
  logic signed [DATA_W-1:0]  t0_r, t1_r, t2_r;

  alu_op_t                  alu_op;
  logic [GAIN_W-1:0]        alu_gain;
  logic signed [DATA_W-1:0] alu_a, alu_b, alu_y;

  logic in_fire, out_free, running;

  cpsp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .gains   (gains)
  );

  cpsp_alu u_alu (
    .op   (alu_op),
    .gain (alu_gain),
    .a    (alu_a),
    .b    (alu_b),
    .y    (alu_y)
  );

  assign cfg_pready   = 1'b1;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign running      = (state_r == ST_RUN);
  assign out_ch.valid = out_valid_r;
  assign out_ch.drive_value = out_drive_r;

  // operand select per step
  always_comb begin
    alu_op   = ALU_ADD;
    alu_gain = '0;
    alu_a    = '0;
    alu_b    = '0;
    unique case (step_r)
      SQ_PERR:  begin alu_op = ALU_SUB; alu_a = pm_r;  alu_b = pt_r;  end
      SQ_PSUM:  begin alu_op = ALU_ADD; alu_a = pes_r; alu_b = t0_r;  end
      SQ_PKP:   begin alu_op = ALU_MUL; alu_gain = gains.pos_kp; alu_a = t0_r;  end
      SQ_PKI:   begin alu_op = ALU_MUL; alu_gain = gains.pos_ki; alu_a = pes_r; end
      SQ_OUTER: begin alu_op = ALU_ADD; alu_a = t1_r;  alu_b = t2_r;  end
      SQ_NEG:   begin alu_op = ALU_SUB; alu_a = '0;    alu_b = t0_r;  end
      SQ_SERR:  begin
        alu_op = ALU_SUB;
        alu_a  = {{(DATA_W-SPEED_W){sp_r[SPEED_W-1]}}, sp_r};
        alu_b  = t0_r;
      end
      SQ_DLT:   begin alu_op = ALU_SUB; alu_a = t1_r;  alu_b = prev_r; end
      SQ_SKP:   begin alu_op = ALU_MUL; alu_gain = gains.spd_kp; alu_a = t0_r; end
      SQ_SKI:   begin alu_op = ALU_MUL; alu_gain = gains.spd_ki; alu_a = t1_r; end
      SQ_INC:   begin alu_op = ALU_ADD; alu_a = t0_r;  alu_b = t2_r;  end
      SQ_DRV:   begin alu_op = ALU_ADD; alu_a = drv_r; alu_b = t0_r;  end
      default: ;
    endcase
  end

  // sequencer and loop state
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    out_drive_nxt = out_drive_r;
    pes_nxt       = pes_r;
    prev_nxt      = prev_r;
    drv_nxt       = drv_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_RUN;
          step_nxt  = SQ_PERR;
        end
      end
      ST_RUN: begin
        if (step_r == SQ_DRV) begin
          if (out_free) begin
            drv_nxt       = alu_y;
            prev_nxt      = t1_r;
            out_drive_nxt = alu_y;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
            step_nxt      = SQ_PERR;
          end
        end else begin
          step_nxt = step_t'(4'(step_r) + 4'd1);
          if (step_r == SQ_PSUM) begin
            pes_nxt = alu_y;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= SQ_PERR;
      out_valid_r <= 1'b0;
      pes_r       <= '0;
      prev_r      <= '0;
      drv_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      pes_r       <= pes_nxt;
      prev_r      <= prev_nxt;
      drv_r       <= drv_nxt;
    end
    out_drive_r <= out_drive_nxt;
  end

  // datapath scratch registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pm_r <= in_ch.position_measured;
      pt_r <= in_ch.position_target;
      sp_r <= in_ch.speed_measured;
    end
    if (running) begin
      case (step_r) inside
        SQ_PERR, SQ_OUTER, SQ_NEG, SQ_DLT, SQ_SKP, SQ_INC: t0_r <= alu_y;
        SQ_PKP, SQ_SERR:                                   t1_r <= alu_y;
        SQ_PKI, SQ_SKI:                                    t2_r <= alu_y;
        default: ;
      endcase
    end
  end

  `CPSP_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_fire, !in_ch.ready)
  `CPSP_ASSERT_IMP(a_result_from_last_step, clk, rst_n, $rose(out_valid_r),
                   $past(running && step_r == SQ_DRV))
  `CPSP_ASSERT_NXT(a_step_advances, clk, rst_n, running && step_r != SQ_DRV,
                   4'(step_r) == 4'($past(step_r)) + 4'd1)
  `CPSP_ASSERT_IMP(a_idle_at_first_step, clk, rst_n, state_r == ST_IDLE, step_r == SQ_PERR)

endmodule

FILE: rtl/cpsp_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsp_alu
// Shared saturating add/subtract and Q8.16 gain multiply.
// ----------------------------------------------------------------------------
module cpsp_alu
  import cpsp_pkg::*;
(
  input  alu_op_t                  op,
  input  logic [GAIN_W-1:0]        gain,
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  output logic signed [DATA_W-1:0] y
);

  localparam int PROD_W = GAIN_W + 1 + DATA_W;
  localparam int QUO_W  = PROD_W - FRAC_W;

  localparam logic signed [DATA_W-1:0] MAX_V = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] MIN_V = {1'b1, {(DATA_W-1){1'b0}}};

  logic [DATA_W:0]          sum;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] biased;
  logic [QUO_W-1:0]         quo;
  logic                     quo_fits;

  always_comb begin
    if (op == ALU_SUB) begin
      sum = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    end else begin
      sum = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    end
  end

  // truncate toward zero: bias negative products before the arithmetic shift
  assign prod   = $signed({1'b0, gain}) * a;
  assign biased = prod + (prod[PROD_W-1] ? PROD_W'(2**FRAC_W - 1) : PROD_W'(0));
  assign quo    = biased[PROD_W-1:FRAC_W];
  assign quo_fits = (&quo[QUO_W-1:DATA_W-1]) || !(|quo[QUO_W-1:DATA_W-1]);

  always_comb begin
    case (op) inside
      ALU_ADD, ALU_SUB: begin
        if (sum[DATA_W] != sum[DATA_W-1]) begin
          y = sum[DATA_W] ? MIN_V : MAX_V;
        end else begin
          y = sum[DATA_W-1:0];
        end
      end
      ALU_MUL: begin
        if (quo_fits) begin
          y = quo[DATA_W-1:0];
        end else begin
          y = quo[QUO_W-1] ? MIN_V : MAX_V;
        end
      end
      default: y = '0;
    endcase
  end

endmodule

FILE: rtl/cpsp_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsp_regs
// APB gain register file: four unsigned Q8.16 gains.
// ----------------------------------------------------------------------------
module cpsp_regs
  import cpsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output gains_t            gains
);

  gains_t gains_r;
  logic   wr_en;
  logic [1:0] reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.pos_kp <= POS_KP_RST;
      gains_r.pos_ki <= POS_KI_RST;
      gains_r.spd_kp <= SPD_KP_RST;
      gains_r.spd_ki <= SPD_KI_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_POS_KP: gains_r.pos_kp <= pwdata[GAIN_W-1:0];
        REG_POS_KI: gains_r.pos_ki <= pwdata[GAIN_W-1:0];
        REG_SPD_KP: gains_r.spd_kp <= pwdata[GAIN_W-1:0];
        REG_SPD_KI: gains_r.spd_ki <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_POS_KP: prdata = CFG_DW'(gains_r.pos_kp);
      REG_POS_KI: prdata = CFG_DW'(gains_r.pos_ki);
      REG_SPD_KP: prdata = CFG_DW'(gains_r.spd_kp);
      REG_SPD_KI: prdata = CFG_DW'(gains_r.spd_ki);
      default:    prdata = '0;
    endcase
  end

  assign gains = gains_r;

endmodule

FILE: tb/sv/cascaded_position_speed_pi_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_position_speed_pi_tb
// Self-checking bench for the cascaded position/speed PI controller. Control
// ticks go in over the valid/ready channel with random gaps, and drive values
// are taken with random stalls. Each drive value is checked against an
// in-bench fixed-point model of both loops. Gains start at reset values and
// are reprogrammed over APB between phases: all ones, all zeros with junk
// upper bits, and random sets.
// ----------------------------------------------------------------------------
module cascaded_position_speed_pi_tb;
  import cpsp_pkg::*;

  localparam int N_DIRECTED    = 14;
  localparam int N_PHASES      = 6;
  localparam int PHASE_TICKS   = 100;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 80;
  localparam int STALL_LIMIT   = 2000;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [63:0] W_MAX   = 64'sd2147483647;
  localparam logic signed [63:0] W_MIN   = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] pos_meas;
    logic signed [31:0] pos_tgt;
    logic signed [15:0] speed;
    bit                 fixed_drive;  // drive value below is known up front
    logic signed [31:0] drive;
  } tick_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  cpsp_in_if  in_ch ();
  cpsp_out_if out_ch ();

  cascaded_position_speed_pi dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // controller model state
  gains_t             gains;
  logic signed [31:0] pos_err_sum;
  logic signed [31:0] prev_speed_err;
  logic signed [31:0] drive_acc;

  logic signed [31:0] expected_drive [$];
  int                 mismatches = 0;
  int                 quiet_cycles = 0;
  bit                 idle_on = 1'b1;
  bit                 hold_req = 1'b0;

  tick_t directed_ticks [N_DIRECTED] = '{
    '{32'sd0,     32'sd0,     16'sd0,       1'b1, 32'sd0},   // fresh after reset
    '{S32_MAX,    S32_MIN,    16'sh7FFF,    1'b1, S32_MAX},  // error, speed and drive pinned high
    '{S32_MIN,    S32_MAX,    16'sh8000,    1'b1, -32'sd1},  // outer at min, negation clips
    '{32'sd0,     32'sd0,     16'sd0,       1'b0, 32'sd0},
    '{-32'sd1,    32'sd0,     16'sd0,       1'b0, 32'sd0},
    '{32'sd1,     32'sd0,     16'sd0,       1'b0, 32'sd0},
    '{32'sd100,   32'sd100,   16'sd1,       1'b0, 32'sd0},
    '{32'sd0,     32'sd0,     -16'sd1,      1'b0, 32'sd0},
    '{32'sd1000,  -32'sd1000, 16'sd500,     1'b0, 32'sd0},
    '{-32'sd2000, 32'sd2000,  -16'sd500,    1'b0, 32'sd0},
    '{S32_MIN,    S32_MIN,    16'sh7FFF,    1'b0, 32'sd0},
    '{S32_MAX,    S32_MAX,    16'sh8000,    1'b0, 32'sd0},
    '{-32'sd1,    S32_MAX,    16'sd0,       1'b0, 32'sd0},
    '{32'sd12345, 32'sd12000, -16'sd123,    1'b0, 32'sd0}
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > W_MAX) return S32_MAX;
    if (v < W_MIN) return S32_MIN;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [63:0] aw;
    logic signed [63:0] bw;
    aw = a;
    bw = b;
    return clamp32(aw + bw);
  endfunction

  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [63:0] aw;
    logic signed [63:0] bw;
    aw = a;
    bw = b;
    return clamp32(aw - bw);
  endfunction

  // Q8.16 gain times signed value, truncated toward zero
  function automatic logic signed [31:0] gain_scale(input logic [GAIN_W-1:0] g,
                                                    input logic signed [31:0] x);
    logic signed [63:0] gw;
    logic signed [63:0] xw;
    logic signed [63:0] prod;
    gw   = {40'd0, g};
    xw   = x;
    prod = gw * xw;
    return clamp32(prod / 64'sd65536);
  endfunction

  function automatic logic signed [31:0] next_drive(input tick_t t);
    logic signed [31:0] pos_err;
    logic signed [31:0] outer;
    logic signed [31:0] speed_tgt;
    logic signed [31:0] speed_w;
    logic signed [31:0] speed_err;
    logic signed [31:0] err_delta;
    logic signed [31:0] incr;
    pos_err     = sub_sat(t.pos_meas, t.pos_tgt);
    pos_err_sum = add_sat(pos_err_sum, pos_err);
    outer       = add_sat(gain_scale(gains.pos_kp, pos_err),
                          gain_scale(gains.pos_ki, pos_err_sum));
    speed_tgt   = sub_sat(32'sd0, outer);
    speed_w     = t.speed;
    speed_err   = sub_sat(speed_w, speed_tgt);
    err_delta   = sub_sat(speed_err, prev_speed_err);
    incr        = add_sat(gain_scale(gains.spd_kp, err_delta),
                          gain_scale(gains.spd_ki, speed_err));
    drive_acc      = add_sat(drive_acc, incr);
    prev_speed_err = speed_err;
    return drive_acc;
  endfunction

  function automatic logic signed [31:0] pick_extreme();
    case ($urandom_range(0, 4))
      0:       return S32_MIN;
      1:       return S32_MAX;
      2:       return -32'sd1;
      3:       return 32'sd1;
      default: return 32'sd0;
    endcase
  endfunction

  // mostly near-target positions with modest speeds, some full range and rails
  function automatic tick_t random_tick();
    tick_t t;
    int    sel;
    t   = '0;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      t.pos_tgt  = $urandom;
      t.pos_meas = t.pos_tgt + 32'($urandom_range(0, 4000)) - 32'd2000;
      t.speed    = 16'($urandom_range(0, 600)) - 16'd300;
    end else if (sel < 8) begin
      t.pos_meas = $urandom;
      t.pos_tgt  = $urandom;
      t.speed    = 16'($urandom);
    end else begin
      t.pos_meas = pick_extreme();
      t.pos_tgt  = pick_extreme();
      t.speed    = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    end
    return t;
  endfunction

  // upper byte is junk that the block must drop
  function automatic logic [31:0] random_gain_word();
    logic [GAIN_W-1:0] g;
    if ($urandom_range(0, 3) == 0) g = GAIN_W'($urandom);
    else g = GAIN_W'($urandom_range(0, 24'h02_0000));
    return {8'($urandom), g};
  endfunction

  task automatic send_tick(input tick_t t);
    int                 gap;
    logic signed [31:0] predicted;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.position_measured <= t.pos_meas;
    in_ch.position_target   <= t.pos_tgt;
    in_ch.speed_measured    <= t.speed;
    do @(posedge clk); while (!in_ch.ready);
    predicted = next_drive(t);
    expected_drive.push_back(t.fixed_drive ? t.drive : predicted);
  endtask

  // leaves psel high so back-to-back writes go straight to the next setup
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_POS_KP: gains.pos_kp = data[GAIN_W-1:0];
      REG_POS_KI: gains.pos_ki = data[GAIN_W-1:0];
      REG_SPD_KP: gains.spd_kp = data[GAIN_W-1:0];
      REG_SPD_KI: gains.spd_ki = data[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_gains(input logic [31:0] w_pos_kp, input logic [31:0] w_pos_ki,
                               input logic [31:0] w_spd_kp, input logic [31:0] w_spd_ki);
    cfg_write(REG_POS_KP, w_pos_kp);
    cfg_write(REG_POS_KI, w_pos_ki);
    cfg_write(REG_SPD_KP, w_spd_kp);
    cfg_write(REG_SPD_KI, w_spd_ki);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (expected_drive.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // stimulus and gain programming
  initial begin
    rst_n                   <= 1'b0;
    in_ch.valid             <= 1'b0;
    in_ch.position_measured <= '0;
    in_ch.position_target   <= '0;
    in_ch.speed_measured    <= '0;
    cfg_psel                <= 1'b0;
    cfg_penable             <= 1'b0;
    cfg_pwrite              <= 1'b0;
    cfg_paddr               <= '0;
    cfg_pwdata              <= '0;
    gains          = '{POS_KP_RST, POS_KI_RST, SPD_KP_RST, SPD_KI_RST};
    pos_err_sum    = '0;
    prev_speed_err = '0;
    drive_acc      = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_tick(directed_ticks[i]);
    end
    in_ch.valid <= 1'b0;

    for (int phase = 0; phase < N_PHASES; phase++) begin
      drain();
      case (phase)
        0: program_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        1: program_gains(32'hFF00_0000, 32'hA500_0000, 32'h5A00_0000, 32'hFF00_0000);
        default: program_gains(random_gain_word(), random_gain_word(),
                               random_gain_word(), random_gain_word());
      endcase
      for (int i = 0; i < PHASE_TICKS; i++) begin
        if (i % 25 == 0) idle_on = ($urandom_range(0, 3) != 0);
        if (phase == 2 && i == 40) hold_req = 1'b1;
        send_tick(random_tick());
      end
      in_ch.valid <= 1'b0;
    end

    drain();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // drive value sink and checker
  initial begin
    int                 stall;
    logic signed [31:0] want;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = idle_on ? $urandom_range(0, 5) : 0;
      if (hold_req) begin
        // long back-pressure: the block fills and stalls its input
        hold_req = 1'b0;
        stall    = HOLD_CYCLES;
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (expected_drive.size() == 0) begin
        $error("drive_value: expected none, got %0d", out_ch.drive_value);
        mismatches++;
      end else begin
        want = expected_drive.pop_front();
        if (out_ch.drive_value !== want) begin
          $error("drive_value: expected %0d, got %0d", want, out_ch.drive_value);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction anywhere
  always @(posedge clk) begin
    if (!rst_n || cfg_psel || (in_ch.valid && in_ch.ready) ||
        (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/cpsp_pkg.sv
rtl/cpsp_if.sv
rtl/cpsp_alu.sv
rtl/cpsp_regs.sv
rtl/cascaded_position_speed_pi.sv
tb/sv/cascaded_position_speed_pi_tb.sv
